>>> design/lrusm_pkg.sv
`timescale 1ns / 1ps

package lrusm_pkg;

    localparam int ID_W      = 32;
    localparam int CNT_OUT_W = 16;

    // All ones marks a site or cluster that is not assigned.
    localparam logic [ID_W-1:0] UNASSIGNED_ID = '1;

    // Operation codes.
    localparam logic [1:0] FUNC_OCCUPY      = 2'd0;
    localparam logic [1:0] FUNC_REMOVE      = 2'd1;
    localparam logic [1:0] FUNC_SET_CLUSTER = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
    localparam logic [1:0] STATUS_UNASSIGNED = 2'd2;

    // Register select (paddr bit 2).
    localparam logic REG_CAPACITY = 1'b0;

    localparam int CAP_MIN = 2;

    typedef struct packed {
        logic [1:0]             func;
        logic signed [ID_W-1:0] site_id;
        logic signed [ID_W-1:0] cluster_id;
    } lrusm_in_t;

    typedef struct packed {
        logic signed [ID_W-1:0] front_site;
        logic signed [ID_W-1:0] front_cluster;
        logic [CNT_OUT_W-1:0]   front_count;
        logic [1:0]             status;
    } lrusm_out_t;

    typedef struct packed {
        logic site_found;
        logic cluster_found;
    } lrusm_match_t;

endpackage

>>> design/lru_site_memory_with_visit_counts_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Word         Handshake
// s_        in         lrusm_in_t   s_valid / s_ready
// m_        out        lrusm_out_t  m_valid / m_ready
// apb       in/out     capacity     psel / penable / pwrite / pready
//
// Each accepted word lands in the input register. While it is held there the lookup
// and table update run, and its result word is loaded into the result register
// once that register can take it. The compare-and-reorder over the register table
// sets the rate of one word per clock when m_ready stays high.
// Reset is synchronous on aresetn low: the table is emptied and the capacity
// returns to two. A stalled result holds the result register, and the input
// register keeps one more word before s_ready drops.

module lru_site_memory_with_visit_counts_core import lrusm_pkg::*; #(
    parameter int MAX_ENTRIES = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lrusm_in_t   s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output lrusm_out_t  m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CAP_W = $clog2(MAX_ENTRIES + 1);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] cap_wdata;
    logic             cap_wr;

    lrusm_in_t  in_item_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    lrusm_out_t m_item_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       advance;
    logic       process;

    logic [ID_W-1:0]        pos_site [MAX_ENTRIES];
    logic [ID_W-1:0]        pos_cluster [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] site_first;
    logic [MAX_ENTRIES-1:0] cluster_first;
    lrusm_match_t           match;
    lrusm_out_t             result;

    // Configuration port. The written capacity is clamped to the legal range.
    assign pready = 1'b1;
    assign cap_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_comb begin
        if (pwdata < 32'(CAP_MIN)) begin
            cap_wdata = CAP_W'(CAP_MIN);
        end else if (pwdata > 32'(MAX_ENTRIES)) begin
            cap_wdata = CAP_W'(MAX_ENTRIES);
        end else begin
            cap_wdata = pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(CAP_MIN);
        end else if (cap_wr) begin
            capacity_reg <= cap_wdata;
        end
    end

    // The held word is worked on whenever the result register can take it.
    assign advance = !m_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign m_valid_next  = process || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (process) begin
            m_item_reg <= result;
        end
    end

    lrusm_match #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_match (
        .capacity     (capacity_reg),
        .site_id      (in_item_reg.site_id),
        .cluster_id   (in_item_reg.cluster_id),
        .pos_site     (pos_site),
        .pos_cluster  (pos_cluster),
        .site_first   (site_first),
        .cluster_first(cluster_first),
        .match        (match)
    );

    lrusm_table #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capacity     (capacity_reg),
        .cap_wr       (cap_wr),
        .cap_wdata    (cap_wdata),
        .process      (process),
        .item         (in_item_reg),
        .site_first   (site_first),
        .cluster_first(cluster_first),
        .match        (match),
        .pos_site     (pos_site),
        .pos_cluster  (pos_cluster),
        .result       (result)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> design/lrusm_match.sv
`timescale 1ns / 1ps

module lrusm_match import lrusm_pkg::*; #(
    parameter int MAX_ENTRIES = 8,
    localparam int CAP_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic [CAP_W-1:0]       capacity,
    input  logic [ID_W-1:0]        site_id,
    input  logic [ID_W-1:0]        cluster_id,
    input  logic [ID_W-1:0]        pos_site [MAX_ENTRIES],
    input  logic [ID_W-1:0]        pos_cluster [MAX_ENTRIES],
    output logic [MAX_ENTRIES-1:0] site_first,
    output logic [MAX_ENTRIES-1:0] cluster_first,
    output lrusm_match_t           match
);

    logic [MAX_ENTRIES-1:0] site_hit;
    logic [MAX_ENTRIES-1:0] cluster_hit;

    // Compare every position in use at once; an unassigned key matches nothing.
    always_comb begin
        for (int p = 0; p < MAX_ENTRIES; p++) begin
            site_hit[p] = (CAP_W'(p) < capacity) && (site_id != UNASSIGNED_ID)
                          && (pos_site[p] == site_id);
            cluster_hit[p] = (CAP_W'(p) < capacity) && (cluster_id != UNASSIGNED_ID)
                             && (pos_cluster[p] == cluster_id);
        end
    end

    // Keep only the most recent hit of each kind.
    assign site_first    = site_hit & (~site_hit + MAX_ENTRIES'(1));
    assign cluster_first = cluster_hit & (~cluster_hit + MAX_ENTRIES'(1));

    assign match.site_found    = |site_hit;
    assign match.cluster_found = |cluster_hit;

endmodule

>>> design/lrusm_table.sv
`timescale 1ns / 1ps

module lrusm_table import lrusm_pkg::*; #(
    parameter int MAX_ENTRIES = 8,
    parameter int COUNT_BITS  = 16,
    localparam int CAP_W = $clog2(MAX_ENTRIES + 1),
    localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CAP_W-1:0]       capacity,
    input  logic                   cap_wr,
    input  logic [CAP_W-1:0]       cap_wdata,
    input  logic                   process,
    input  lrusm_in_t              item,
    input  logic [MAX_ENTRIES-1:0] site_first,
    input  logic [MAX_ENTRIES-1:0] cluster_first,
    input  lrusm_match_t           match,
    output logic [ID_W-1:0]        pos_site [MAX_ENTRIES],
    output logic [ID_W-1:0]        pos_cluster [MAX_ENTRIES],
    output lrusm_out_t             result
);

    // The table is held in recency order: position 0 is the most recent.
    logic [ID_W-1:0]       site_reg [MAX_ENTRIES];
    logic [ID_W-1:0]       cluster_reg [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [MAX_ENTRIES];
    logic [ID_W-1:0]       site_next [MAX_ENTRIES];
    logic [ID_W-1:0]       cluster_next [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_next [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] sel_oh;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W-1:0]       last_idx;
    logic [ID_W-1:0]        new_site;
    logic [ID_W-1:0]        new_cluster;
    logic [COUNT_BITS-1:0]  new_count;
    logic [COUNT_BITS-1:0]  sel_count;
    logic [1:0]             status;
    logic [31:0]            front_count_wide;

    assign pos_site    = site_reg;
    assign pos_cluster = cluster_reg;
    assign last_idx    = IDX_W'(capacity - CAP_W'(1));

    // Pick the position the operation acts on.
    always_comb begin
        if (item.func == FUNC_OCCUPY && match.cluster_found) begin
            sel_oh = cluster_first;
        end else if (item.func == FUNC_OCCUPY && !match.site_found) begin
            for (int p = 0; p < MAX_ENTRIES; p++) begin
                sel_oh[p] = (IDX_W'(p) == last_idx);
            end
        end else begin
            sel_oh = site_first;
        end
        sel_idx = '0;
        for (int p = 0; p < MAX_ENTRIES; p++) begin
            if (sel_oh[p]) begin
                sel_idx = sel_idx | IDX_W'(p);
            end
        end
    end

    // The entry that an occupy moves to the front.
    always_comb begin
        sel_count = count_reg[sel_idx];
        new_site    = site_reg[sel_idx];
        new_cluster = cluster_reg[sel_idx];
        new_count   = (sel_count == '1) ? sel_count : sel_count + COUNT_BITS'(1);
        if (!match.cluster_found && !match.site_found) begin
            new_site    = item.site_id;
            new_cluster = item.cluster_id;
            new_count   = COUNT_BITS'(1);
        end else if (match.cluster_found && !match.site_found) begin
            new_site = item.site_id;
        end
    end

    always_comb begin
        site_next    = site_reg;
        cluster_next = cluster_reg;
        count_next   = count_reg;
        status       = STATUS_OK;
        case (item.func)
            FUNC_OCCUPY: begin
                if (item.site_id == UNASSIGNED_ID) begin
                    status = STATUS_UNASSIGNED;
                end else begin
                    for (int p = 0; p < MAX_ENTRIES; p++) begin
                        if (p == 0) begin
                            site_next[p]    = new_site;
                            cluster_next[p] = new_cluster;
                            count_next[p]   = new_count;
                        end else if (IDX_W'(p) <= sel_idx) begin
                            site_next[p]    = site_reg[p-1];
                            cluster_next[p] = cluster_reg[p-1];
                            count_next[p]   = count_reg[p-1];
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                if (!match.site_found) begin
                    status = STATUS_NOT_FOUND;
                end else begin
                    // Close the gap and park the cleared entry at the back.
                    for (int p = 0; p < MAX_ENTRIES; p++) begin
                        if (IDX_W'(p) == last_idx) begin
                            site_next[p]    = UNASSIGNED_ID;
                            cluster_next[p] = UNASSIGNED_ID;
                            count_next[p]   = '0;
                        end else if (p < MAX_ENTRIES - 1) begin
                            if (IDX_W'(p) >= sel_idx && IDX_W'(p) < last_idx) begin
                                site_next[p]    = site_reg[p+1];
                                cluster_next[p] = cluster_reg[p+1];
                                count_next[p]   = count_reg[p+1];
                            end
                        end
                    end
                end
            end
            FUNC_SET_CLUSTER: begin
                if (!match.site_found) begin
                    status = STATUS_NOT_FOUND;
                end else begin
                    for (int p = 0; p < MAX_ENTRIES; p++) begin
                        if (site_first[p]) begin
                            cluster_next[p] = item.cluster_id;
                        end
                    end
                end
            end
            default: begin
                status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_ENTRIES; p++) begin
                site_reg[p]    <= UNASSIGNED_ID;
                cluster_reg[p] <= UNASSIGNED_ID;
                count_reg[p]   <= '0;
            end
        end else if (cap_wr) begin
            // Shrinking the table clears everything past the new end.
            for (int p = 0; p < MAX_ENTRIES; p++) begin
                if (CAP_W'(p) >= cap_wdata) begin
                    site_reg[p]    <= UNASSIGNED_ID;
                    cluster_reg[p] <= UNASSIGNED_ID;
                    count_reg[p]   <= '0;
                end
            end
        end else if (process) begin
            site_reg    <= site_next;
            cluster_reg <= cluster_next;
            count_reg   <= count_next;
        end
    end

    assign front_count_wide = 32'(count_next[0]);

    always_comb begin
        result.front_site    = site_next[0];
        result.front_cluster = cluster_next[0];
        result.front_count   = (|front_count_wide[31:CNT_OUT_W]) ? '1
                               : front_count_wide[CNT_OUT_W-1:0];
        result.status        = status;
    end

endmodule
